### rtl/core/erit_pkg.sv
// shared types, constants and helpers for the euler rotation inverse transform
package erit_pkg;

  localparam int COEF_FRAC_BITS_DEF = 30;

  localparam int ANG_W   = 20;
  localparam int COORD_W = 31;
  localparam int OUT_W   = 32;
  localparam int REG_W   = 31;
  localparam int IDX_W   = 2;

  // angles in millidegrees
  localparam int FULL_TURN    = 360000;
  localparam int QUARTER_TURN = 90000;
  localparam int EIGHTH_TURN  = 45000;

  // 0.01745329252 / 1000 in q50
  localparam logic [34:0] RAD_PER_MDEG_Q50 = 35'd19650660422;

  localparam logic [30:0] QONE = 31'd1 << 30;

  localparam int TAYLOR_TERMS = 6;
  // reduce, fold, radians, square, three stages per term, sign map
  localparam int TRIG_LAT = 4 + 3 * TAYLOR_TERMS + 1;
  localparam int MAT_LAT  = 6;

  localparam logic signed [31:0] TRANS_LIMIT = 32'sd1999999998;

  // series divisors and floor(2^32 / divisor)
  localparam logic [7:0]  SIN_DIVS   [TAYLOR_TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110,
                                                        8'd156};
  localparam logic [31:0] SIN_RECIPS [TAYLOR_TERMS] = '{32'd715827882, 32'd214748364,
                                                        32'd102261126, 32'd59652323,
                                                        32'd39045157, 32'd27531841};
  localparam logic [7:0]  COS_DIVS   [TAYLOR_TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90,
                                                        8'd132};
  localparam logic [31:0] COS_RECIPS [TAYLOR_TERMS] = '{32'd2147483648, 32'd357913941,
                                                        32'd143165576, 32'd76695844,
                                                        32'd47721858, 32'd32537631};

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } cfg_reg_t;

  typedef logic signed [31:0] trig_t;
  typedef logic signed [32:0] cof_t;
  typedef logic signed [33:0] det_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sincos_t;

  // running state of the sine / cosine series
  typedef struct packed {
    logic [30:0]        st;
    logic [30:0]        ct;
    logic [30:0]        r2;
    logic signed [32:0] ss;
    logic signed [32:0] cs;
    quad_t              quad;
    logic               swap;
  } taylor_t;

  // round a q60 product sum to q30, half up
  function automatic logic signed [63:0] rq30(input logic signed [63:0] v);
    return (v + 64'sd536870912) >>> 30;
  endfunction

endpackage

### rtl/core/erit_term.sv
// one taylor step of sine and cosine, three pipeline stages
module erit_term import erit_pkg::*; #(
  parameter logic [7:0]  SIN_DIV   = 8'd6,
  parameter logic [31:0] SIN_RECIP = 32'd715827882,
  parameter logic [7:0]  COS_DIV   = 8'd2,
  parameter logic [31:0] COS_RECIP = 32'd2147483648,
  parameter bit          SUBTRACT  = 1'b1
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  taylor_t in_t,
  output logic    out_valid,
  output taylor_t out_t
);

  localparam logic [61:0] RND29 = 62'd1 << 29;

  logic        a_valid_r, b_valid_r;
  taylor_t     a_t_r, b_t_r;
  logic [30:0] a_ps_r, a_pc_r, b_ps_r, b_pc_r, b_qs_r, b_qc_r;
  logic [30:0] a_ps_nxt, a_pc_nxt, b_qs_nxt, b_qc_nxt;
  logic [38:0] prod_s, prod_c;
  logic [39:0] rem_s, rem_c;
  logic [30:0] st_nxt, ct_nxt;
  taylor_t     out_nxt;

  // previous term times r squared
  always_comb begin
    a_ps_nxt = 31'((62'(in_t.st) * 62'(in_t.r2) + RND29) >> 30);
    a_pc_nxt = 31'((62'(in_t.ct) * 62'(in_t.r2) + RND29) >> 30);
  end

  // quotient estimate, at most one low
  always_comb begin
    b_qs_nxt = 31'((63'(a_ps_r) * 63'(SIN_RECIP)) >> 32);
    b_qc_nxt = 31'((63'(a_pc_r) * 63'(COS_RECIP)) >> 32);
  end

  always_comb begin
    prod_s  = 39'(b_qs_r) * 39'(SIN_DIV);
    prod_c  = 39'(b_qc_r) * 39'(COS_DIV);
    rem_s   = 40'(b_ps_r) - 40'(prod_s);
    rem_c   = 40'(b_pc_r) - 40'(prod_c);
    st_nxt  = (rem_s >= 40'(SIN_DIV)) ? b_qs_r + 31'd1 : b_qs_r;
    ct_nxt  = (rem_c >= 40'(COS_DIV)) ? b_qc_r + 31'd1 : b_qc_r;
    out_nxt = b_t_r;
    out_nxt.st = st_nxt;
    out_nxt.ct = ct_nxt;
    if (SUBTRACT) begin
      out_nxt.ss = b_t_r.ss - $signed(33'(st_nxt));
      out_nxt.cs = b_t_r.cs - $signed(33'(ct_nxt));
    end else begin
      out_nxt.ss = b_t_r.ss + $signed(33'(st_nxt));
      out_nxt.cs = b_t_r.cs + $signed(33'(ct_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      out_valid <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_t_r  <= in_t;
    a_ps_r <= a_ps_nxt;
    a_pc_r <= a_pc_nxt;
    b_t_r  <= a_t_r;
    b_ps_r <= a_ps_r;
    b_pc_r <= a_pc_r;
    b_qs_r <= b_qs_nxt;
    b_qc_r <= b_qc_nxt;
    out_t  <= out_nxt;
  end

endmodule

### rtl/core/erit_trig.sv
// pipelined sine and cosine of a negated angle in millidegrees
module erit_trig import erit_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic signed [ANG_W-1:0] in_angle,
  output logic                    out_valid,
  output sincos_t                 out_sc
);

  logic               s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r;
  logic [18:0]        s1_m_r, s1_m_nxt;
  logic [15:0]        s2_x_r, s2_x_nxt;
  quad_t              s2_q_r, s3_q_r, s2_q_nxt;
  logic               s2_swap_r, s3_swap_r, s2_swap_nxt;
  logic [30:0]        s3_r_r, s3_r_nxt;
  taylor_t            s4_t_r, s4_t_nxt;
  logic signed [21:0] ang_ext, neg_ang;
  logic [16:0]        t_val;
  logic [50:0]        rad_sum;
  logic [61:0]        sq_sum;
  logic               term_v [TAYLOR_TERMS+1];
  taylor_t            term_t [TAYLOR_TERMS+1];
  logic [30:0]        ss_cl, cs_cl, ps_v, pc_v;
  trig_t              ps_s, pc_s;
  sincos_t            out_nxt;

  // reduce the negated angle to [0, full turn)
  always_comb begin
    ang_ext = {{2{in_angle[ANG_W-1]}}, in_angle};
    neg_ang = 22'sd0 - ang_ext;
    priority if (neg_ang < 22'sd0) begin
      if (neg_ang + 22'(FULL_TURN) < 22'sd0) begin
        s1_m_nxt = 19'(neg_ang + 22'(2 * FULL_TURN));
      end else begin
        s1_m_nxt = 19'(neg_ang + 22'(FULL_TURN));
      end
    end else if (neg_ang >= 22'(FULL_TURN)) begin
      s1_m_nxt = 19'(neg_ang - 22'(FULL_TURN));
    end else begin
      s1_m_nxt = 19'(neg_ang);
    end
  end

  // quadrant and octant fold
  always_comb begin
    priority if (s1_m_r < 19'(QUARTER_TURN)) begin
      s2_q_nxt = QUAD_0;
      t_val    = 17'(s1_m_r);
    end else if (s1_m_r < 19'(2 * QUARTER_TURN)) begin
      s2_q_nxt = QUAD_1;
      t_val    = 17'(s1_m_r - 19'(QUARTER_TURN));
    end else if (s1_m_r < 19'(3 * QUARTER_TURN)) begin
      s2_q_nxt = QUAD_2;
      t_val    = 17'(s1_m_r - 19'(2 * QUARTER_TURN));
    end else begin
      s2_q_nxt = QUAD_3;
      t_val    = 17'(s1_m_r - 19'(3 * QUARTER_TURN));
    end
    s2_swap_nxt = t_val > 17'(EIGHTH_TURN);
    s2_x_nxt    = s2_swap_nxt ? 16'(17'(QUARTER_TURN) - t_val) : 16'(t_val);
  end

  always_comb begin
    rad_sum  = 51'(s2_x_r) * 51'(RAD_PER_MDEG_Q50) + (51'd1 << 19);
    s3_r_nxt = rad_sum[50:20];
    sq_sum   = 62'(s3_r_r) * 62'(s3_r_r) + (62'd1 << 29);
    s4_t_nxt.st   = s3_r_r;
    s4_t_nxt.ct   = QONE;
    s4_t_nxt.r2   = sq_sum[60:30];
    s4_t_nxt.ss   = $signed(33'(s3_r_r));
    s4_t_nxt.cs   = $signed(33'(QONE));
    s4_t_nxt.quad = s3_q_r;
    s4_t_nxt.swap = s3_swap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_m_r    <= s1_m_nxt;
    s2_x_r    <= s2_x_nxt;
    s2_q_r    <= s2_q_nxt;
    s2_swap_r <= s2_swap_nxt;
    s3_r_r    <= s3_r_nxt;
    s3_q_r    <= s2_q_r;
    s3_swap_r <= s2_swap_r;
    s4_t_r    <= s4_t_nxt;
  end

  assign term_v[0] = s4_valid_r;
  assign term_t[0] = s4_t_r;

  for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_term
    erit_term #(
      .SIN_DIV   (SIN_DIVS[k]),
      .SIN_RECIP (SIN_RECIPS[k]),
      .COS_DIV   (COS_DIVS[k]),
      .COS_RECIP (COS_RECIPS[k]),
      .SUBTRACT  ((k % 2) == 0)
    ) u_term (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (term_v[k]),
      .in_t      (term_t[k]),
      .out_valid (term_v[k+1]),
      .out_t     (term_t[k+1])
    );
  end

  // clamp to [0, 1], undo the fold, apply quadrant signs
  always_comb begin
    priority if (term_t[TAYLOR_TERMS].ss < 33'sd0) begin
      ss_cl = '0;
    end else if (term_t[TAYLOR_TERMS].ss > $signed(33'(QONE))) begin
      ss_cl = QONE;
    end else begin
      ss_cl = term_t[TAYLOR_TERMS].ss[30:0];
    end
    priority if (term_t[TAYLOR_TERMS].cs < 33'sd0) begin
      cs_cl = '0;
    end else if (term_t[TAYLOR_TERMS].cs > $signed(33'(QONE))) begin
      cs_cl = QONE;
    end else begin
      cs_cl = term_t[TAYLOR_TERMS].cs[30:0];
    end
    ps_v = term_t[TAYLOR_TERMS].swap ? cs_cl : ss_cl;
    pc_v = term_t[TAYLOR_TERMS].swap ? ss_cl : cs_cl;
    ps_s = $signed({1'b0, ps_v});
    pc_s = $signed({1'b0, pc_v});
    unique case (term_t[TAYLOR_TERMS].quad)
      QUAD_0: begin
        out_nxt.s = ps_s;
        out_nxt.c = pc_s;
      end
      QUAD_1: begin
        out_nxt.s = pc_s;
        out_nxt.c = -ps_s;
      end
      QUAD_2: begin
        out_nxt.s = -ps_s;
        out_nxt.c = -pc_s;
      end
      default: begin
        out_nxt.s = -pc_s;
        out_nxt.c = ps_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= term_v[TAYLOR_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    out_sc <= out_nxt;
  end

endmodule

### rtl/core/erit_mat.sv
// rotation product, cofactors and determinant, six pipeline stages
module erit_mat import erit_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  sincos_t        in_a,
  input  sincos_t        in_c,
  output logic           out_valid,
  output cof_t [8:0]     out_cof,
  output det_t           out_det
);

  logic               m1_valid_r, m2_valid_r, m3_valid_r, m4_valid_r, m5_valid_r;
  logic signed [63:0] m1_casc_r, m1_cacc_r, m1_sasc_r, m1_sacc_r;
  trig_t              m1_sa_r, m1_ca_r, m1_sc_r, m1_cc_r;
  trig_t              f_r [9];
  trig_t              f_nxt [9];
  logic signed [63:0] pa_r [9];
  logic signed [63:0] pb_r [9];
  trig_t              m3_row_r [3];
  trig_t              m4_row_r [3];
  cof_t               cof4_r [9];
  cof_t               cof5_r [9];
  logic signed [63:0] dp_r [3];
  logic signed [63:0] det_full;

  always_ff @(posedge clk) begin
    m1_casc_r <= in_a.c * in_c.s;
    m1_cacc_r <= in_a.c * in_c.c;
    m1_sasc_r <= in_a.s * in_c.s;
    m1_sacc_r <= in_a.s * in_c.c;
    m1_sa_r   <= in_a.s;
    m1_ca_r   <= in_a.c;
    m1_sc_r   <= in_c.s;
    m1_cc_r   <= in_c.c;
  end

  // transpose(ra) * transpose(rc), row major
  always_comb begin
    f_nxt[0] = m1_cc_r;
    f_nxt[1] = -m1_sc_r;
    f_nxt[2] = '0;
    f_nxt[3] = 32'(rq30(m1_casc_r));
    f_nxt[4] = 32'(rq30(m1_cacc_r));
    f_nxt[5] = -m1_sa_r;
    f_nxt[6] = 32'(rq30(m1_sasc_r));
    f_nxt[7] = 32'(rq30(m1_sacc_r));
    f_nxt[8] = m1_ca_r;
  end

  always_ff @(posedge clk) begin
    f_r <= f_nxt;
  end

  for (genvar gi = 0; gi < 3; gi++) begin : g_row
    for (genvar gj = 0; gj < 3; gj++) begin : g_col
      localparam int I1 = (gi + 1) % 3;
      localparam int I2 = (gi + 2) % 3;
      localparam int J1 = (gj + 1) % 3;
      localparam int J2 = (gj + 2) % 3;
      always_ff @(posedge clk) begin
        pa_r[gi*3+gj]   <= f_r[J1*3+I1] * f_r[J2*3+I2];
        pb_r[gi*3+gj]   <= f_r[J1*3+I2] * f_r[J2*3+I1];
        cof4_r[gi*3+gj] <= 33'(rq30(pa_r[gi*3+gj] - pb_r[gi*3+gj]));
      end
    end
  end

  always_ff @(posedge clk) begin
    m3_row_r <= '{f_r[0], f_r[1], f_r[2]};
    m4_row_r <= m3_row_r;
    dp_r[0]  <= m4_row_r[0] * cof4_r[0];
    dp_r[1]  <= m4_row_r[1] * cof4_r[3];
    dp_r[2]  <= m4_row_r[2] * cof4_r[6];
    cof5_r   <= cof4_r;
  end

  assign det_full = rq30(dp_r[0] + dp_r[1] + dp_r[2]);

  always_ff @(posedge clk) begin
    out_det <= 34'(det_full);
    for (int i = 0; i < 9; i++) begin
      out_cof[i] <= cof5_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_valid_r <= 1'b0;
      m2_valid_r <= 1'b0;
      m3_valid_r <= 1'b0;
      m4_valid_r <= 1'b0;
      m5_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      m1_valid_r <= in_valid;
      m2_valid_r <= m1_valid_r;
      m3_valid_r <= m2_valid_r;
      m4_valid_r <= m3_valid_r;
      m5_valid_r <= m4_valid_r;
      out_valid  <= m5_valid_r;
    end
  end

endmodule

### rtl/core/erit_div.sv
// pipelined restoring divider, one quotient bit per stage, rounded and saturated
module erit_div import erit_pkg::*; #(
  parameter int FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  cof_t                    in_cof,
  input  det_t                    in_det,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] out_q
);

  localparam int QB = FRAC_BITS + 2;
  localparam int RW = FRAC_BITS + 36;
  localparam logic [QB-1:0] LIM = QB'(1) << FRAC_BITS;

  logic [RW-1:0] rem_r  [QB+1];
  logic [QB-1:0] quo_r  [QB+1];
  logic [32:0]   dmag_r [QB+1];
  logic          neg_r  [QB+1];
  logic          pos_r  [QB+1];
  logic          big_r  [QB+1];
  logic          vld_r  [QB+1];
  logic [32:0]   cmag, dmag;
  logic [RW-1:0] num;
  logic [QB-1:0] mag_q;

  // |num| plus half the divisor, and a flag for a quotient far past the limit
  always_comb begin
    cmag = in_cof[32] ? 33'(-in_cof) : 33'(in_cof);
    dmag = in_det[32:0];
    num  = (RW'(cmag) << FRAC_BITS) + RW'(dmag >> 1);
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= num;
    quo_r[0]  <= '0;
    dmag_r[0] <= dmag;
    neg_r[0]  <= in_cof[32];
    pos_r[0]  <= in_det > 34'sd0;
    big_r[0]  <= num >= (RW'(dmag) << QB);
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    localparam int B = QB - 1 - j;
    logic [RW-1:0] sub;
    logic          ge;
    always_comb begin
      sub = RW'(dmag_r[j]) << B;
      ge  = rem_r[j] >= sub;
    end
    always_ff @(posedge clk) begin
      rem_r[j+1]  <= ge ? rem_r[j] - sub : rem_r[j];
      quo_r[j+1]  <= quo_r[j] | (QB'(ge) << B);
      dmag_r[j+1] <= dmag_r[j];
      neg_r[j+1]  <= neg_r[j];
      pos_r[j+1]  <= pos_r[j];
      big_r[j+1]  <= big_r[j];
    end
  end

  assign mag_q = (big_r[QB] || quo_r[QB] > LIM) ? LIM : quo_r[QB];

  always_ff @(posedge clk) begin
    if (!pos_r[QB]) begin
      out_q <= '0;
    end else if (neg_r[QB]) begin
      out_q <= -OUT_W'(mag_q);
    end else begin
      out_q <= OUT_W'(mag_q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
      for (int i = 0; i < QB; i++) begin
        vld_r[i+1] <= vld_r[i];
      end
      out_valid <= vld_r[QB];
    end
  end

endmodule

### rtl/core/euler_rotation_inverse_transform.sv
// top level: inverse of the a/c euler rotation plus offset translation
//
// one word is taken on every clock where start is high; busy never rises, so
// words may follow back to back with no gaps. each word comes out as a
// single-cycle out_valid strobe with all twelve result ports; the receiver
// must capture it then, there is no hold-off. the path is fully pipelined:
// angle reduction and six taylor steps for sine/cosine (23 stages), matrix
// product, cofactors and determinant (6 stages), and nine parallel dividers
// that resolve one quotient bit per stage (COEF_FRAC_BITS + 4 stages).
// offsets are written through cfg_we/cfg_index/cfg_data and take effect for
// the next word; write them only with no word in flight. index 3 is ignored.
// there is no clearing pass after reset.
module euler_rotation_inverse_transform import erit_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [ANG_W-1:0]   in_angle_a,
  input  logic signed [ANG_W-1:0]   in_angle_c,
  input  logic signed [COORD_W-1:0] in_cycle_x,
  input  logic signed [COORD_W-1:0] in_cycle_y,
  input  logic signed [COORD_W-1:0] in_cycle_z,
  input  logic                      cfg_we,
  input  logic [IDX_W-1:0]          cfg_index,
  input  logic [REG_W-1:0]          cfg_data,
  output logic                      out_valid,
  output logic signed [OUT_W-1:0]   out_inv_r0c0,
  output logic signed [OUT_W-1:0]   out_inv_r0c1,
  output logic signed [OUT_W-1:0]   out_inv_r0c2,
  output logic signed [OUT_W-1:0]   out_inv_r1c0,
  output logic signed [OUT_W-1:0]   out_inv_r1c1,
  output logic signed [OUT_W-1:0]   out_inv_r1c2,
  output logic signed [OUT_W-1:0]   out_inv_r2c0,
  output logic signed [OUT_W-1:0]   out_inv_r2c1,
  output logic signed [OUT_W-1:0]   out_inv_r2c2,
  output logic signed [OUT_W-1:0]   out_trans_x,
  output logic signed [OUT_W-1:0]   out_trans_y,
  output logic signed [OUT_W-1:0]   out_trans_z
);

  // delay line length, from accept to the result strobe
  localparam int LAT = TRIG_LAT + MAT_LAT + COEF_FRAC_BITS + 4;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } trans_t;

  logic                    accept;
  logic signed [REG_W-1:0] offset_x_r, offset_y_r, offset_z_r;
  trans_t                  trans_nxt;
  trans_t                  trans_dly_r [LAT];
  logic                    trig_a_valid;
  sincos_t                 sc_a, sc_c;
  logic                    mat_valid;
  cof_t [8:0]              cof;
  det_t                    det;
  logic signed [OUT_W-1:0] inv [9];

  function automatic logic signed [OUT_W-1:0] sat_trans(input logic signed [OUT_W-1:0] v);
    if (v > TRANS_LIMIT) begin
      return TRANS_LIMIT;
    end else if (v < -TRANS_LIMIT) begin
      return -TRANS_LIMIT;
    end
    return v;
  endfunction

  // fully pipelined, never stalls
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_y_r <= '0;
      offset_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_OFFSET_X: offset_x_r <= $signed(cfg_data);
        REG_OFFSET_Y: offset_y_r <= $signed(cfg_data);
        REG_OFFSET_Z: offset_z_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // translations are ready at once and ride a delay line to meet the matrix
  always_comb begin
    trans_nxt.x = sat_trans(OUT_W'(offset_x_r) + OUT_W'(in_cycle_x));
    trans_nxt.y = sat_trans(OUT_W'(offset_y_r) + OUT_W'(in_cycle_y));
    trans_nxt.z = sat_trans(OUT_W'(offset_z_r) + OUT_W'(in_cycle_z));
  end

  always_ff @(posedge clk) begin
    trans_dly_r[0] <= trans_nxt;
    for (int i = 1; i < LAT; i++) begin
      trans_dly_r[i] <= trans_dly_r[i-1];
    end
  end

  // sine/cosine of -a and -c run side by side with equal latency
  erit_trig u_trig_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_angle  (in_angle_a),
    .out_valid (trig_a_valid),
    .out_sc    (sc_a)
  );

  erit_trig u_trig_c (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_angle  (in_angle_c),
    .out_valid (),
    .out_sc    (sc_c)
  );

  erit_mat u_mat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (trig_a_valid),
    .in_a      (sc_a),
    .in_c      (sc_c),
    .out_valid (mat_valid),
    .out_cof   (cof),
    .out_det   (det)
  );

  // one divider per inverse entry, all sharing the determinant
  for (genvar i = 0; i < 9; i++) begin : g_div
    if (i == 0) begin : g_lead
      erit_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_cof    (cof[i]),
        .in_det    (det),
        .out_valid (out_valid),
        .out_q     (inv[i])
      );
    end else begin : g_rest
      erit_div #(.FRAC_BITS(COEF_FRAC_BITS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_cof    (cof[i]),
        .in_det    (det),
        .out_valid (),
        .out_q     (inv[i])
      );
    end
  end

  assign out_inv_r0c0 = inv[0];
  assign out_inv_r0c1 = inv[1];
  assign out_inv_r0c2 = inv[2];
  assign out_inv_r1c0 = inv[3];
  assign out_inv_r1c1 = inv[4];
  assign out_inv_r1c2 = inv[5];
  assign out_inv_r2c0 = inv[6];
  assign out_inv_r2c1 = inv[7];
  assign out_inv_r2c2 = inv[8];
  assign out_trans_x  = trans_dly_r[LAT-1].x;
  assign out_trans_y  = trans_dly_r[LAT-1].y;
  assign out_trans_z  = trans_dly_r[LAT-1].z;

endmodule
